>>> src/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the segment load and translate unit
// Segment numbers, access modes, configuration register indexes and the
// record kept for each segment register.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  // Segment register file
  localparam int unsigned SEG_COUNT = 6;
  localparam int unsigned SEG_IDX_W = 3;
  localparam logic [SEG_IDX_W-1:0] SEG_CS = 3'd1;
  localparam logic [SEG_IDX_W-1:0] SEG_SS = 3'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A20_ENABLED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GDT_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LDT_LIMIT      = 2'd3;

  // Access byte and flag bit positions inside the attribute field
  localparam int unsigned ATTR_RW   = 1;
  localparam int unsigned ATTR_EC   = 2;
  localparam int unsigned ATTR_CODE = 3;
  localparam int unsigned ATTR_DPL  = 5;
  localparam int unsigned ATTR_G    = 10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EXEC  = 2'd2,
    OP_LOAD  = 2'd3
  } mode_e;

  // One segment register with its descriptor cache
  typedef struct packed {
    logic [15:0] selector;
    logic [31:0] base;
    logic [19:0] limit;
    logic [10:0] attr;
  } seg_entry_t;

  // One input item
  typedef struct packed {
    mode_e                mode;
    logic [SEG_IDX_W-1:0] segment;
    logic [31:0]          offset;
    logic [15:0]          selector;
    logic [63:0]          descriptor_word;
  } item_t;

  // One result item
  typedef struct packed {
    logic [31:0] address;
    logic        fault;
  } result_t;

  // Control registers seen by the execute logic
  typedef struct packed {
    logic        protected_mode;
    logic        a20_enabled;
    logic [15:0] gdt_limit;
    logic [15:0] ldt_limit;
  } cfg_t;

  // Segment register update from the execute logic
  typedef struct packed {
    logic                 we;
    logic [SEG_IDX_W-1:0] idx;
    seg_entry_t           entry;
  } seg_wr_t;

endpackage

`default_nettype wire

>>> src/slt_ifs.sv
// ----------------------------------------------------------------------------
// slt_ifs: valid/ready channels of the segment load and translate unit
// Input channel carries a load or translate request, output channel the
// translated address or new base with a fault flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  segment;
  logic [31:0] offset;
  logic [15:0] selector;
  logic [63:0] descriptor_word;

  modport source (output valid, mode, segment, offset, selector, descriptor_word,
                  input ready);
  modport sink   (input valid, mode, segment, offset, selector, descriptor_word,
                  output ready);
endinterface

interface slt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        fault;

  modport source (output valid, address, fault, input ready);
  modport sink   (input valid, address, fault, output ready);
endinterface

`default_nettype wire

>>> src/slt_exec.sv
// ----------------------------------------------------------------------------
// slt_exec: single-pass load and translate logic
// Given one registered item, the addressed segment register and the CS
// selector, forms the result beat and the segment register update.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_exec
  import slt_pkg::*;
(
  input  item_t      item_i,
  input  seg_entry_t entry_i,
  input  logic [1:0] cpl_i,
  input  cfg_t       cfg_i,
  output result_t    result_o,
  output seg_wr_t    wr_o
);

  logic        seg_ok;
  logic [15:0] tbl_idx;
  logic [15:0] tbl_lim;
  logic        load_fault;
  seg_entry_t  new_entry;
  logic [31:0] lim_scaled;
  logic [1:0]  dpl;
  logic        rw;
  logic        ec;
  logic        is_code;
  logic        type_fault;
  logic [31:0] base_eff;
  logic [31:0] lin_addr;
  logic [31:0] masked_addr;
  logic        xlat_fault;
  logic        is_load;

  assign seg_ok  = (item_i.segment < SEG_IDX_W'(SEG_COUNT));
  assign is_load = (item_i.mode == OP_LOAD);

  // Load: table checks and descriptor unpacking, or the real-mode base from the selector
  assign tbl_idx = {item_i.selector[15:3], 3'b000};
  assign tbl_lim = item_i.selector[2] ? cfg_i.ldt_limit : cfg_i.gdt_limit;

  always_comb begin
    load_fault = 1'b0;
    new_entry  = entry_i;
    new_entry.selector = item_i.selector;
    if (cfg_i.protected_mode) begin
      if (((item_i.segment == SEG_CS) || (item_i.segment == SEG_SS)) &&
          (tbl_idx == 16'h0000)) begin
        load_fault = 1'b1;
      end
      if (tbl_idx > tbl_lim) begin
        load_fault = 1'b1;
      end
      new_entry.base  = {item_i.descriptor_word[63:56], item_i.descriptor_word[39:16]};
      new_entry.limit = {item_i.descriptor_word[51:48], item_i.descriptor_word[15:0]};
      new_entry.attr  = {item_i.descriptor_word[55], item_i.descriptor_word[54],
                         item_i.descriptor_word[52], item_i.descriptor_word[47:40]};
    end else begin
      new_entry.base = {12'h000, item_i.selector, 4'h0};
    end
  end

  // Translate: type and privilege checks, limit scaling
  assign dpl     = entry_i.attr[ATTR_DPL +: 2];
  assign rw      = entry_i.attr[ATTR_RW];
  assign ec      = entry_i.attr[ATTR_EC];
  assign is_code = entry_i.attr[ATTR_CODE];
  assign lim_scaled = entry_i.attr[ATTR_G] ? {entry_i.limit, 12'h000}
                                           : {12'h000, entry_i.limit};

  always_comb begin
    type_fault = 1'b0;
    if (is_code) begin
      if (item_i.mode == OP_WRITE) begin
        type_fault = 1'b1;
      end
      if ((item_i.mode == OP_READ) && !rw) begin
        type_fault = 1'b1;
      end
      if ((cpl_i > dpl) && !((item_i.mode == OP_EXEC) && ec)) begin
        type_fault = 1'b1;
      end
    end else begin
      if (item_i.mode == OP_EXEC) begin
        type_fault = 1'b1;
      end
      if ((item_i.mode == OP_WRITE) && !rw) begin
        type_fault = 1'b1;
      end
      if (cpl_i > dpl) begin
        type_fault = 1'b1;
      end
    end
  end

  // Expand-down data segments sit below the base
  assign base_eff = (!is_code && ec) ? (entry_i.base - lim_scaled) : entry_i.base;

  always_comb begin
    if (cfg_i.protected_mode) begin
      xlat_fault = type_fault || (item_i.offset > lim_scaled);
      lin_addr   = base_eff + item_i.offset;
    end else begin
      xlat_fault = 1'b0;
      lin_addr   = {12'h000, entry_i.selector, 4'h0} + item_i.offset;
    end
  end

  // Drop address bits 31..20 while the A20 gate is closed
  assign masked_addr = cfg_i.a20_enabled ? lin_addr : {12'h000, lin_addr[19:0]};

  // Pick the result and the register update
  always_comb begin
    result_o = '0;
    wr_o     = '0;
    wr_o.idx   = item_i.segment;
    wr_o.entry = new_entry;
    if (!seg_ok) begin
      result_o.fault = 1'b1;
    end else if (is_load) begin
      if (load_fault) begin
        result_o.fault = 1'b1;
      end else begin
        result_o.address = new_entry.base;
        wr_o.we          = 1'b1;
      end
    end else if (xlat_fault) begin
      result_o.fault = 1'b1;
    end else begin
      result_o.address = masked_addr;
    end
  end

endmodule

`default_nettype wire

>>> src/segment_load_and_translate_top.sv
// ----------------------------------------------------------------------------
// segment_load_and_translate_top: segment register file with address
// translation
// Holds six segment registers with descriptor caches, loads selectors and
// translates offsets into linear addresses with protection checks.
// ----------------------------------------------------------------------------
// Each item passes through the input register, where the load or translate
// logic runs, and then the result register. As long as the output side keeps
// taking results, a new item is taken in every cycle and results come at one
// per cycle. A load updates the segment register at the edge its result is
// registered, so the very next item already sees the new base, limit and
// attributes. Configuration writes take effect on the following edge.
`default_nettype none

module segment_load_and_translate_top
  import slt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  slt_in_if.sink                     in_i,
  slt_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  seg_entry_t seg_q [SEG_COUNT];
  logic       s1_valid_q;
  item_t      s1_item_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       s1_advance;
  seg_entry_t entry_rd;
  result_t    result_d;
  seg_wr_t    seg_wr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROTECTED_MODE: cfg_q.protected_mode <= cfg_wdata_i[0];
        CFG_A20_ENABLED:    cfg_q.a20_enabled    <= cfg_wdata_i[0];
        CFG_GDT_LIMIT:      cfg_q.gdt_limit      <= cfg_wdata_i;
        CFG_LDT_LIMIT:      cfg_q.ldt_limit      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Advance the input register when the result register is free or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.mode            <= mode_e'(in_i.mode);
      s1_item_q.segment         <= in_i.segment;
      s1_item_q.offset          <= in_i.offset;
      s1_item_q.selector        <= in_i.selector;
      s1_item_q.descriptor_word <= in_i.descriptor_word;
    end
  end

  // Read the addressed segment register; out-of-range numbers fault anyway
  assign entry_rd = (s1_item_q.segment < SEG_IDX_W'(SEG_COUNT)) ?
                    seg_q[s1_item_q.segment] : '0;

  slt_exec u_exec (
    .item_i   (s1_item_q),
    .entry_i  (entry_rd),
    .cpl_i    (seg_q[SEG_CS].selector[1:0]),
    .cfg_i    (cfg_q),
    .result_o (result_d),
    .wr_o     (seg_wr)
  );

  // Segment register file, written when a load retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEG_COUNT; i++) begin
        seg_q[i] <= '0;
      end
    end else if (s1_advance && seg_wr.we) begin
      seg_q[seg_wr.idx] <= seg_wr.entry;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.address = out_q.address;
  assign out_o.fault   = out_q.fault;

endmodule

`default_nettype wire

>>> src/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker: port-level assertions for the segment translate unit
// Watches the channel handshakes and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_address_i,
  input wire logic        out_fault_i
);

  // A faulting beat carries a zero address
  a_fault_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_fault_i) |-> (out_address_i == 32'h0))
    else $error("fault beat with nonzero address");

  // With the result register free or draining, the input side must be open
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while result register can take a beat");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_address_i) && $stable(out_fault_i)))
    else $error("stalled result beat changed");

endmodule

bind segment_load_and_translate_top slt_checker u_slt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_address_i (out_o.address),
  .out_fault_i   (out_o.fault)
);

`default_nettype wire
